// File: hdl/dq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, request codes, status codes and ring arithmetic for the
// double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = IDX_W + 1;
  localparam int REQ_W      = 3;
  localparam int STATUS_W   = 2;

  localparam logic [REQ_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] OP_CLEAR      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(DEPTH);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Reduces a sum below twice the depth to a ring index.
  function automatic idx_t dq_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= DEPTH_SUM) ? (s - DEPTH_SUM) : s;
    return r[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/dq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/double_ended_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Double-ended queue of data words held in a ring memory with a head index
// and a count. Each request pushes or pops at either end or clears the queue.
// ----------------------------------------------------------------------------
// Sequence: an accepted request writes the entry and moves head and count;
// in S_READ the RAMs read the new front and back words, and in S_RESP the
// registered words are shown with out_strobe for exactly one cycle.
// A new request is taken only in S_IDLE; busy is high in S_READ and S_RESP.
// Reset: rst_n clears head, count and sequencer; the ring needs no clearing.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [dq_pkg::REQ_W-1:0]         in_req_type,
  input  wire logic [dq_pkg::DATA_WIDTH-1:0]    in_push_value,
  output logic                                  out_strobe,
  output logic      [dq_pkg::DATA_WIDTH-1:0]    out_front_value,
  output logic      [dq_pkg::DATA_WIDTH-1:0]    out_back_value,
  output logic      [dq_pkg::CNT_W-1:0]         out_entry_count,
  output logic      [dq_pkg::STATUS_W-1:0]      out_status
);
  import dq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]          state_r, state_nxt;
  idx_t                head_r, head_nxt;
  cnt_t                count_r, count_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic                  accept;
  logic                  wr_en;
  idx_t                  wr_addr;
  idx_t                  back_addr;
  cnt_t                  count_m1;
  logic [DATA_WIDTH-1:0] front_rd, back_rd;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign count_m1 = count_r - cnt_t'(1);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = dq_wrap(SUM_W'(head_r) + SUM_W'(count_r));
    if (accept) begin
      status_nxt = ST_OK;
      unique case (in_req_type)
        OP_PUSH_FRONT: begin
          if (count_r == COUNT_FULL) begin
            status_nxt = ST_FULL;
          end else begin
            head_nxt  = (head_r == '0) ? IDX_LAST : head_r - idx_t'(1);
            wr_addr   = head_nxt;
            wr_en     = 1'b1;
            count_nxt = count_r + cnt_t'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (count_r == COUNT_FULL) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + cnt_t'(1);
          end
        end
        OP_POP_FRONT: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_nxt  = dq_wrap(SUM_W'(head_r) + SUM_W'(1));
            count_nxt = count_m1;
          end
        end
        OP_POP_BACK: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            count_nxt = count_m1;
          end
        end
        OP_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_READ : S_IDLE;
      S_READ:  state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  assign back_addr = (count_r == '0) ? head_r : dq_wrap(SUM_W'(head_r) + SUM_W'(count_m1));

  dq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_front_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_push_value),
    .raddr (head_r),
    .rdata (front_rd)
  );

  dq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_back_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_push_value),
    .raddr (back_addr),
    .rdata (back_rd)
  );

  assign out_strobe      = (state_r == S_RESP);
  assign out_front_value = (count_r == '0) ? '0 : front_rd;
  assign out_back_value  = (count_r == '0) ? '0 : back_rd;
  assign out_entry_count = count_r;
  assign out_status      = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("Stored count exceeds the ring depth.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_strobe)
    else $error("Result did not follow an accepted request.");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_FULL) |-> (out_entry_count == COUNT_FULL))
    else $error("Full status reported while the ring is not full.");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_EMPTY) |-> (out_entry_count == '0))
    else $error("Empty status reported while the ring holds words.");

  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!accept && !busy) |=> ($stable(head_r) && $stable(count_r)))
    else $error("Ring pointers moved without a request.");

endmodule
`default_nettype wire
